[hw/rtl/ndrm_pkg.sv]
// ----------------------------------------------------------------------------
// ndrm_pkg
// shared types and constants for the descriptor ring manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndrm_pkg;

  localparam int TX_SLOTS = 16;
  localparam int RX_SLOTS = 32;
  localparam int TX_IW    = $clog2(TX_SLOTS);
  localparam int RX_IW    = $clog2(RX_SLOTS);

  localparam int ACT_W    = 2;
  localparam int LEN_W    = 16;
  localparam int SLOT_W   = 5;
  localparam int FRAME_W  = 11;
  localparam int DROP_W   = 6;
  localparam int STAT_W   = 2;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 11;

  localparam logic [FRAME_W-1:0] MIN_FRAME_RST = FRAME_W'(60);
  localparam logic [FRAME_W-1:0] MAX_FRAME_RST = FRAME_W'(1518);
  localparam logic [DROP_W-1:0]  DROP_MAX      = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEND    = 2'd0,
    ACT_RECV    = 2'd1,
    ACT_TX_DONE = 2'd2,
    ACT_RX_FILL = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RING_ENABLE = 2'd0,
    CFG_MIN_FRAME   = 2'd1,
    CFG_MAX_FRAME   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RX_FETCH,
    S_RX_STEP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture input beat
    logic finish;    // commit item and load result register
    logic rx_fetch;  // read frame length at receive index
    logic rx_skip;   // free errored frame and advance
  } ndrm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rx_go;     // receive request that must walk the ring
    logic rx_skip;   // current receive slot holds an errored frame
    logic out_free;  // result register can take a new beat
  } ndrm_stat_t;

endpackage

`default_nettype wire

[hw/rtl/nic_descriptor_ring_manager_unit.sv]
// ----------------------------------------------------------------------------
// nic_descriptor_ring_manager_unit
// transmit and receive descriptor ring manager, one result beat per request
// ----------------------------------------------------------------------------
//
//   channel  handshake         payload
//   -------  ----------------  ------------------------------------------------
//   in       in_valid/ready    action, length, slot, error_flag
//   out      out_valid/ready   status, byte_count, used_slot, tail_write,
//                              tail_index, dropped
//   cfg      cfg_we            cfg_index, cfg_data (write only)
//
// send, rejected receive and device events are captured, then executed into the
// result register. a receive request that walks the ring is captured, executed,
// then fetches one slot of the frame length memory per step, freeing each
// errored frame that it meets. reset takes effect at once, no clearing pass.
// a stalled result beat holds the next item in its last step until the result
// register frees.
//
`timescale 1ns / 1ps
`default_nettype none

module nic_descriptor_ring_manager_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ndrm_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [ndrm_pkg::CFG_DW-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ndrm_pkg::ACT_W-1:0]   in_action,
  input  wire logic [ndrm_pkg::LEN_W-1:0]   in_length,
  input  wire logic [ndrm_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic                         in_error_flag,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ndrm_pkg::STAT_W-1:0]       out_status,
  output logic [ndrm_pkg::LEN_W-1:0]        out_byte_count,
  output logic [ndrm_pkg::SLOT_W-1:0]       out_used_slot,
  output logic                              out_tail_write,
  output logic [ndrm_pkg::SLOT_W-1:0]       out_tail_index,
  output logic [ndrm_pkg::DROP_W-1:0]       out_dropped
);
  import ndrm_pkg::*;

  ndrm_cmd_t  cmd;
  ndrm_stat_t stat;

  ndrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ndrm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (in_action),
    .in_length      (in_length),
    .in_slot        (in_slot),
    .in_error_flag  (in_error_flag),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_byte_count (out_byte_count),
    .out_used_slot  (out_used_slot),
    .out_tail_write (out_tail_write),
    .out_tail_index (out_tail_index),
    .out_dropped    (out_dropped)
  );

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free)
    else $error("result register overwritten");

  // an accepted beat blocks the input for at least the execute cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // a new result appears only from a finish command
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // rejected items carry no tail write and no drops
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_REJECT)) |-> (!out_tail_write && (out_dropped == '0)))
    else $error("rejected item with side effects");

endmodule

`default_nettype wire

[hw/rtl/ndrm_ctrl.sv]
// ----------------------------------------------------------------------------
// ndrm_ctrl
// sequencer: accepts a beat, runs the receive walk, hands off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndrm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ndrm_pkg::ndrm_stat_t stat,
  output ndrm_pkg::ndrm_cmd_t      cmd
);
  import ndrm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.rx_go) state_nxt = S_RX_FETCH;
        else if (stat.out_free) state_nxt = S_IDLE;
      end
      S_RX_FETCH: begin
        state_nxt = S_RX_STEP;
      end
      S_RX_STEP: begin
        // each skip clears the errored slot's flags, so a full lap always ends the walk
        if (stat.rx_skip) state_nxt = S_RX_FETCH;
        else if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.finish = !stat.rx_go && stat.out_free;
      end
      S_RX_FETCH: begin
        cmd.rx_fetch = 1'b1;
      end
      S_RX_STEP: begin
        cmd.rx_skip = stat.rx_skip;
        cmd.finish  = !stat.rx_skip && stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/ndrm_datapath.sv]
// ----------------------------------------------------------------------------
// ndrm_datapath
// ring indices, slot flags, frame length memory, config and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndrm_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ndrm_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [ndrm_pkg::CFG_DW-1:0]  cfg_data,
  input  wire logic [ndrm_pkg::ACT_W-1:0]   in_action,
  input  wire logic [ndrm_pkg::LEN_W-1:0]   in_length,
  input  wire logic [ndrm_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic                         in_error_flag,
  input  wire ndrm_pkg::ndrm_cmd_t          cmd,
  output ndrm_pkg::ndrm_stat_t              stat,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ndrm_pkg::STAT_W-1:0]       out_status,
  output logic [ndrm_pkg::LEN_W-1:0]        out_byte_count,
  output logic [ndrm_pkg::SLOT_W-1:0]       out_used_slot,
  output logic                              out_tail_write,
  output logic [ndrm_pkg::SLOT_W-1:0]       out_tail_index,
  output logic [ndrm_pkg::DROP_W-1:0]       out_dropped
);
  import ndrm_pkg::*;

  // configuration
  logic               ring_en_r;
  logic [FRAME_W-1:0] min_frame_r;
  logic [FRAME_W-1:0] max_frame_r;

  // ring state
  logic [TX_IW-1:0]    tx_next_r, tx_next_nxt;
  logic [TX_SLOTS-1:0] tx_done_r, tx_done_nxt;
  logic [RX_IW-1:0]    rx_next_r, rx_next_nxt;
  logic [RX_SLOTS-1:0] rx_done_r, rx_done_nxt;
  logic [RX_SLOTS-1:0] rx_err_r, rx_err_nxt;
  logic [LEN_W-1:0]    rx_len_mem [RX_SLOTS];
  logic [LEN_W-1:0]    rx_len_rd_r;

  // captured beat and walk bookkeeping
  action_t           act_r;
  logic [LEN_W-1:0]  len_r;
  logic [SLOT_W-1:0] slot_r;
  logic              err_r;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic              tw_r, tw_nxt;
  logic [SLOT_W-1:0] ti_r, ti_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  status_t           res_status, out_status_r;
  logic [LEN_W-1:0]  res_bytes, out_bytes_r;
  logic [SLOT_W-1:0] res_used, out_used_r;
  logic              res_tw, out_tw_r;
  logic [SLOT_W-1:0] res_ti, out_ti_r;
  logic [DROP_W-1:0] res_drop, out_drop_r;

  logic               send_rej, recv_rej, tx_slot_bad, rx_slot_bad;
  logic [TX_IW-1:0]   tx_adv;
  logic [RX_IW-1:0]   rx_adv;
  logic [FRAME_W-1:0] pad_len;
  logic [LEN_W-1:0]   rx_clip;
  logic               we_mem;

  assign send_rej    = !ring_en_r || (len_r == '0) ||
                       (len_r > LEN_W'(max_frame_r));
  assign recv_rej    = !ring_en_r || (len_r == '0);
  assign tx_slot_bad = {1'b0, slot_r} >= (SLOT_W+1)'(TX_SLOTS);
  assign rx_slot_bad = {1'b0, slot_r} >= (SLOT_W+1)'(RX_SLOTS);
  assign tx_adv      = (tx_next_r == TX_IW'(TX_SLOTS - 1)) ? '0 : tx_next_r + 1'b1;
  assign rx_adv      = (rx_next_r == RX_IW'(RX_SLOTS - 1)) ? '0 : rx_next_r + 1'b1;
  // length is already bounded by max_frame here, so the low bits are the value
  assign pad_len     = (len_r[FRAME_W-1:0] < min_frame_r) ? min_frame_r
                                                          : len_r[FRAME_W-1:0];
  assign rx_clip     = (rx_len_rd_r > len_r) ? len_r : rx_len_rd_r;

  assign stat.rx_go    = (act_r == ACT_RECV) && !recv_rej;
  assign stat.rx_skip  = rx_done_r[rx_next_r] && rx_err_r[rx_next_r];
  assign stat.out_free = !out_valid_r || out_ready;

  // result and state update for the captured beat
  always_comb begin
    res_status  = ST_OK;
    res_bytes   = '0;
    res_used    = '0;
    res_tw      = 1'b0;
    res_ti      = '0;
    res_drop    = '0;
    tx_next_nxt = tx_next_r;
    tx_done_nxt = tx_done_r;
    rx_next_nxt = rx_next_r;
    rx_done_nxt = rx_done_r;
    rx_err_nxt  = rx_err_r;
    drop_nxt    = drop_r;
    tw_nxt      = tw_r;
    ti_nxt      = ti_r;
    we_mem      = 1'b0;

    if (cmd.latch) begin
      drop_nxt = '0;
      tw_nxt   = 1'b0;
      ti_nxt   = '0;
    end

    if (cmd.rx_skip) begin
      rx_done_nxt[rx_next_r] = 1'b0;
      rx_err_nxt[rx_next_r]  = 1'b0;
      rx_next_nxt            = rx_adv;
      tw_nxt                 = 1'b1;
      ti_nxt                 = SLOT_W'(rx_next_r);
      if (drop_r != DROP_MAX) drop_nxt = drop_r + 1'b1;
    end

    unique case (act_r)
      ACT_SEND: begin
        if (send_rej) begin
          res_status = ST_REJECT;
        end else if (!tx_done_r[tx_next_r]) begin
          res_status = ST_EMPTY;
        end else begin
          res_bytes = LEN_W'(pad_len);
          res_used  = SLOT_W'(tx_next_r);
          res_tw    = 1'b1;
          res_ti    = SLOT_W'(tx_adv);
          if (cmd.finish) begin
            tx_done_nxt[tx_next_r] = 1'b0;
            tx_next_nxt            = tx_adv;
          end
        end
      end
      ACT_RECV: begin
        if (recv_rej) begin
          res_status = ST_REJECT;
        end else begin
          res_tw   = tw_r;
          res_ti   = ti_r;
          res_drop = drop_r;
          if (rx_done_r[rx_next_r]) begin
            res_bytes = rx_clip;
            res_used  = SLOT_W'(rx_next_r);
            res_tw    = 1'b1;
            res_ti    = SLOT_W'(rx_next_r);
            if (cmd.finish) begin
              rx_done_nxt[rx_next_r] = 1'b0;
              rx_next_nxt            = rx_adv;
            end
          end else begin
            res_status = ST_EMPTY;
          end
        end
      end
      ACT_TX_DONE: begin
        if (tx_slot_bad) begin
          res_status = ST_REJECT;
        end else begin
          res_used = slot_r;
          if (cmd.finish) tx_done_nxt[TX_IW'(slot_r)] = 1'b1;
        end
      end
      ACT_RX_FILL: begin
        if (rx_slot_bad) begin
          res_status = ST_REJECT;
        end else begin
          res_used = slot_r;
          if (cmd.finish) begin
            rx_done_nxt[RX_IW'(slot_r)] = 1'b1;
            rx_err_nxt[RX_IW'(slot_r)]  = err_r;
            we_mem                      = 1'b1;
          end
        end
      end
      default: res_status = ST_REJECT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_en_r   <= 1'b0;
      min_frame_r <= MIN_FRAME_RST;
      max_frame_r <= MAX_FRAME_RST;
      tx_next_r   <= '0;
      tx_done_r   <= '1;
      rx_next_r   <= '0;
      rx_done_r   <= '0;
      rx_err_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_RING_ENABLE: ring_en_r   <= cfg_data[0];
          CFG_MIN_FRAME:   min_frame_r <= cfg_data[FRAME_W-1:0];
          CFG_MAX_FRAME:   max_frame_r <= cfg_data[FRAME_W-1:0];
          default:         ring_en_r   <= ring_en_r;
        endcase
      end
      tx_next_r   <= tx_next_nxt;
      tx_done_r   <= tx_done_nxt;
      rx_next_r   <= rx_next_nxt;
      rx_done_r   <= rx_done_nxt;
      rx_err_r    <= rx_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= action_t'(in_action);
      len_r  <= in_length;
      slot_r <= in_slot;
      err_r  <= in_error_flag;
    end
    drop_r <= drop_nxt;
    tw_r   <= tw_nxt;
    ti_r   <= ti_nxt;
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_bytes_r  <= res_bytes;
      out_used_r   <= res_used;
      out_tw_r     <= res_tw;
      out_ti_r     <= res_ti;
      out_drop_r   <= res_drop;
    end
  end

  // frame length memory
  always_ff @(posedge clk) begin
    if (we_mem) rx_len_mem[RX_IW'(slot_r)] <= len_r;
    if (cmd.rx_fetch) rx_len_rd_r <= rx_len_mem[rx_next_r];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_byte_count = out_bytes_r;
  assign out_used_slot  = out_used_r;
  assign out_tail_write = out_tw_r;
  assign out_tail_index = out_ti_r;
  assign out_dropped    = out_drop_r;

endmodule

`default_nettype wire
